/* rtl/core/rhpt_pkg.sv */
// Shared constants, codes and control/status structs of the pointer table.
// No dependencies; every other file of the core imports this package.
`timescale 1ns / 1ps

package rhpt_pkg;

  localparam int SLOTS   = 1024;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int W1      = IDX_W + 1;
  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 32;
  localparam int OCC_W   = 11;
  localparam int CFG_W   = 11;
  localparam int MODE_W  = 2;
  localparam int STEP_W  = 7;
  localparam int HASH_STEPS = KEY_W;

  localparam logic [CFG_W-1:0]  SLOTS_RESET = 11'd1024;
  localparam logic [MODE_W-1:0] MODE_RESET  = 2'd1;

  localparam logic CFG_SLOTS = 1'b0;
  localparam logic CFG_MODE  = 1'b1;

  localparam logic [31:0] C_SIMPLE = 32'h045d9f3b;
  localparam logic [31:0] C_GOLDEN = 32'd2654435761;
  localparam logic [63:0] C_MIX1   = 64'h7ed55d16;
  localparam logic [63:0] C_MIX2   = 64'hc761c23c;
  localparam logic [63:0] C_MIX3   = 64'h165667b1;
  localparam logic [63:0] C_MIX4   = 64'hd3a2646c;
  localparam logic [63:0] C_MIX5   = 64'hfd7046c5;
  localparam logic [63:0] C_MIX6   = 64'hb55a4f09;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_LOOKUP = 2'd1,
    K_REMOVE = 2'd2,
    K_UPDATE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_HOME,
    POS_NEXT,
    POS_INC,
    POS_HOLE_NEXT
  } pos_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_CARRY,
    WR_BYTES,
    WR_COPY,
    WR_HOLE_CLR
  } wr_sel_e;

  typedef enum logic {
    REM_HASH,
    REM_HOME
  } rem_sel_e;

  typedef struct packed {
    logic     latch;
    logic     mix_start;
    logic     rem_start;
    rem_sel_e rem_sel;
    logic     home_load;
    pos_sel_e pos_sel;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     dist_load;
    wr_sel_e  wr_sel;
    logic     carry_init;
    logic     carry_swap;
    logic     d_step;
    logic     hole_load;
    logic     room_set;
    logic     res_found;
    logic     res_bytes_op;
    logic     res_status_we;
    status_e  res_status;
    logic     total_inc;
    logic     total_dec;
  } dp_cmd_t;

  typedef struct packed {
    logic  mix_done;
    logic  rem_done;
    logic  empty;
    logic  key_eq;
    logic  dist_lt_cnt;
    logic  carry_ge;
    logic  dist_zero;
    logic  cnt_last;
    logic  nx_is_hole;
    logic  clr_last;
    logic  room;
    kind_e kind;
  } dp_stat_t;

endpackage

/* rtl/core/robin_hood_pointer_table_core.sv */
// Top level of the Robin Hood pointer table: controller plus datapath.
// Depends on rhpt_pkg, rhpt_ctrl and rhpt_datapath.
//
// One operation at a time: an operation is taken when start is high and busy
// is low, and its single result is shown for one cycle with done_o, which
// the receiver must take then. After reset the block clears all SLOTS (1024)
// slots of the home array, one slot a cycle, with busy high; configuration
// writes are taken at any time. An operation mixes the key, reduces it
// bit-serially to the home slot and then starts the probe. Each occupied slot
// probed is read from memory and its resident's home is reduced to find its
// distance; an empty slot is only read. Insert and remove run a second pass
// over the slots they move, and an insert whose lookup met no empty slot
// first scans for one. The result is shown in the cycle after the last step.
// The serial remainder unit and the registered reads of the slot memory set
// the cost of each step.
`timescale 1ns / 1ps

module robin_hood_pointer_table_core import rhpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [SIZE_W-1:0] byte_size_i,
  input  logic              is_root_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [SIZE_W-1:0] found_size_o,
  output logic              found_root_o,
  output logic [OCC_W-1:0]  occupied_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rhpt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  rhpt_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (kind_i),
    .key_i           (key_i),
    .byte_size_i     (byte_size_i),
    .is_root_i       (is_root_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .status_o        (status_o),
    .found_size_o    (found_size_o),
    .found_root_o    (found_root_o),
    .occupied_count_o(occupied_count_o)
  );

endmodule

/* rtl/core/rhpt_mix.sv */
// Key mixing unit: three selectable integer hashes and the golden multiply.
// One step per cycle, 64-bit multiplies split in two 32-bit halves. Uses rhpt_pkg.
`timescale 1ns / 1ps

module rhpt_mix import rhpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [KEY_W-1:0]  key_i,
  output logic              done_o,
  output logic [KEY_W-1:0]  x_o
);

  localparam logic [3:0] OP_XS16 = 4'd0;
  localparam logic [3:0] OP_MKA  = 4'd1;
  localparam logic [3:0] OP_MKB  = 4'd2;
  localparam logic [3:0] OP_MGA  = 4'd3;
  localparam logic [3:0] OP_MGB  = 4'd4;
  localparam logic [3:0] OP_SHR3 = 4'd5;
  localparam logic [3:0] OP_M1   = 4'd6;
  localparam logic [3:0] OP_M2   = 4'd7;
  localparam logic [3:0] OP_END  = 4'd8;

  function automatic logic [3:0] op_at(input logic [MODE_W-1:0] mode, input logic [3:0] step);
    logic [3:0] op;
    op = OP_END;
    unique case (mode)
      2'd1, 2'd2: begin
        if (step < 4'd6) begin
          op = (mode == 2'd1) ? OP_M1 : OP_M2;
        end else if (step == 4'd6) begin
          op = OP_SHR3;
        end else if (step == 4'd7) begin
          op = OP_MGA;
        end else if (step == 4'd8) begin
          op = OP_MGB;
        end
      end
      default: begin
        unique case (step)
          4'd0, 4'd3, 4'd6: op = OP_XS16;
          4'd1, 4'd4:       op = OP_MKA;
          4'd2, 4'd5:       op = OP_MKB;
          4'd7:             op = OP_SHR3;
          4'd8:             op = OP_MGA;
          4'd9:             op = OP_MGB;
          default:          op = OP_END;
        endcase
      end
    endcase
    return op;
  endfunction

  logic              run_q, done_q;
  logic [3:0]        step_q;
  logic [MODE_W-1:0] mode_q;
  logic [KEY_W-1:0]  x_q, x_d, acc_q;
  logic [3:0]        op;
  logic [31:0]       mul_a, mul_c;
  logic [63:0]       prod;

  assign op    = op_at(mode_q, step_q);
  assign mul_a = (op == OP_MKB || op == OP_MGB) ? x_q[63:32] : x_q[31:0];
  assign mul_c = (op == OP_MKA || op == OP_MKB) ? C_SIMPLE : C_GOLDEN;
  assign prod  = mul_a * mul_c;

  always_comb begin
    x_d = x_q;
    case (op)
      OP_XS16: x_d = (x_q >> 16) ^ x_q;
      OP_SHR3: x_d = x_q >> 3;
      OP_MKB, OP_MGB: x_d = acc_q + {prod[31:0], 32'h0};
      OP_M1: begin
        case (step_q[2:0])
          3'd0:    x_d = (x_q + C_MIX1) + (x_q << 12);
          3'd1:    x_d = (x_q ^ C_MIX2) ^ (x_q >> 19);
          3'd2:    x_d = (x_q + C_MIX3) + (x_q << 5);
          3'd3:    x_d = (x_q + C_MIX4) ^ (x_q << 9);
          3'd4:    x_d = (x_q + C_MIX5) + (x_q << 3);
          default: x_d = (x_q ^ C_MIX6) ^ (x_q >> 16);
        endcase
      end
      OP_M2: begin
        case (step_q[2:0])
          3'd0:    x_d = (~x_q) + (x_q << 18);
          3'd1:    x_d = x_q ^ (x_q >> 31);
          3'd2:    x_d = (x_q << 4) + (x_q << 2) + x_q;
          3'd3:    x_d = x_q ^ (x_q >> 11);
          3'd4:    x_d = x_q + (x_q << 6);
          default: x_d = x_q ^ (x_q >> 22);
        endcase
      end
      default: x_d = x_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 4'd1;
        if (op == OP_END) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= key_i;
      mode_q <= mode_i;
    end else if (run_q) begin
      x_q <= x_d;
      if (op == OP_MKA || op == OP_MGA) begin
        acc_q <= prod;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;

endmodule

/* rtl/core/rhpt_rem.sv */
// Bit-serial remainder unit: one dividend bit per cycle, MSB first.
// Shared by the home reduction and the probe distance. Uses rhpt_pkg.
`timescale 1ns / 1ps

module rhpt_rem import rhpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [KEY_W-1:0]  x_i,
  input  logic [STEP_W-1:0] steps_i,
  input  logic [CNT_W-1:0]  n_i,
  output logic              done_o,
  output logic [CNT_W-1:0]  r_o
);

  logic              run_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [KEY_W-1:0]  x_q;
  logic [CNT_W-1:0]  r_q;
  logic [CNT_W:0]    t, t_d;

  assign t   = {r_q, x_q[KEY_W-1]};
  assign t_d = (t >= {1'b0, n_i}) ? (t - {1'b0, n_i}) : t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= steps_i;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      r_q <= '0;
    end else if (run_q) begin
      x_q <= x_q << 1;
      r_q <= t_d[CNT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

/* rtl/core/rhpt_datapath.sv */
// Table datapath: slot memories, probe registers, carried entry, results.
// Instantiates rhpt_mix and rhpt_rem; driven by rhpt_ctrl. Uses rhpt_pkg.
`timescale 1ns / 1ps

module rhpt_datapath import rhpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic [1:0]        kind_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [SIZE_W-1:0] byte_size_i,
  input  logic              is_root_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output logic [1:0]        status_o,
  output logic [SIZE_W-1:0] found_size_o,
  output logic              found_root_o,
  output logic [OCC_W-1:0]  occupied_count_o
);

  logic [KEY_W-1:0]  mem_key   [SLOTS];
  logic [SIZE_W-1:0] mem_bytes [SLOTS];
  logic              mem_root  [SLOTS];
  logic [CNT_W-1:0]  mem_hpo   [SLOTS];

  logic [KEY_W-1:0]  rd_key_q;
  logic [SIZE_W-1:0] rd_bytes_q;
  logic              rd_root_q;
  logic [CNT_W-1:0]  rd_hpo_q;

  logic [CFG_W-1:0]  cfg_slots_q;
  logic [MODE_W-1:0] cfg_mode_q;

  kind_e             kind_q;
  logic [KEY_W-1:0]  key_q;
  logic [SIZE_W-1:0] bytes_q;
  logic              root_q;
  logic [CNT_W-1:0]  n_q;
  logic [IDX_W-1:0]  home_q, pos_q, pos_d, hole_q, d_q, dist_q;
  logic [CNT_W-1:0]  cnt_q, total_q;
  logic [KEY_W-1:0]  ck_q;
  logic [SIZE_W-1:0] cb_q;
  logic              cr_q, room_q;
  logic [CNT_W-1:0]  cpo_q;
  status_e           status_q;
  logic [SIZE_W-1:0] fsize_q;
  logic              froot_q;

  logic              mix_done, rem_done;
  logic [KEY_W-1:0]  mix_x, rem_x;
  logic [STEP_W-1:0] rem_steps;
  logic [CNT_W-1:0]  rem_r, hpo_m1;
  logic [31:0]       slots_ext, n32;
  logic [W1-1:0]     pos_p1, hole_p1, dsum, dt;
  logic [IDX_W-1:0]  pos_nx, hole_nx, dist_d, d_base, d_nx;

  logic              we_key, we_bytes, we_root, we_hpo;
  logic [IDX_W-1:0]  wa;
  logic [KEY_W-1:0]  wk;
  logic [SIZE_W-1:0] wb;
  logic              wr;
  logic [CNT_W-1:0]  wh;

  rhpt_mix u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mix_start),
    .mode_i (cfg_mode_q),
    .key_i  (key_i),
    .done_o (mix_done),
    .x_o    (mix_x)
  );

  assign hpo_m1    = rd_hpo_q - 1'b1;
  assign rem_x     = (cmd_i.rem_sel == REM_HASH) ? mix_x :
                     {hpo_m1[IDX_W-1:0], {(KEY_W-IDX_W){1'b0}}};
  assign rem_steps = (cmd_i.rem_sel == REM_HASH) ? STEP_W'(HASH_STEPS) : STEP_W'(IDX_W);

  rhpt_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.rem_start),
    .x_i    (rem_x),
    .steps_i(rem_steps),
    .n_i    (n_q),
    .done_o (rem_done),
    .r_o    (rem_r)
  );

  assign slots_ext = 32'(cfg_slots_q);
  assign n32 = (slots_ext == 32'd0) ? 32'd1 :
               (slots_ext > 32'(SLOTS)) ? 32'(SLOTS) : slots_ext;

  assign pos_p1  = W1'(pos_q) + W1'(1);
  assign pos_nx  = (pos_p1 == W1'(n_q)) ? '0 : pos_p1[IDX_W-1:0];
  assign hole_p1 = W1'(hole_q) + W1'(1);
  assign hole_nx = (hole_p1 == W1'(n_q)) ? '0 : hole_p1[IDX_W-1:0];

  assign dsum   = W1'(pos_q) + W1'(n_q) - W1'(rem_r);
  assign dist_d = (dsum >= W1'(n_q)) ? IDX_W'(dsum - W1'(n_q)) : IDX_W'(dsum);

  assign d_base = cmd_i.carry_swap ? dist_q : d_q;
  assign dt     = W1'(d_base) + W1'(1);
  assign d_nx   = (dt == W1'(n_q)) ? '0 : dt[IDX_W-1:0];

  always_comb begin
    unique case (cmd_i.pos_sel)
      POS_HOME:      pos_d = home_q;
      POS_NEXT:      pos_d = pos_nx;
      POS_INC:       pos_d = pos_q + 1'b1;
      POS_HOLE_NEXT: pos_d = hole_nx;
      default:       pos_d = pos_q;
    endcase
  end

  always_comb begin
    we_key   = 1'b0;
    we_bytes = 1'b0;
    we_root  = 1'b0;
    we_hpo   = 1'b0;
    wa       = pos_q;
    wk       = ck_q;
    wb       = cb_q;
    wr       = cr_q;
    wh       = cpo_q;
    case (cmd_i.wr_sel)
      WR_CLEAR: begin
        we_hpo = 1'b1;
        wh     = '0;
      end
      WR_CARRY: begin
        {we_key, we_bytes, we_root, we_hpo} = 4'hf;
      end
      WR_BYTES: begin
        we_bytes = 1'b1;
        wb       = bytes_q;
      end
      WR_COPY: begin
        {we_key, we_bytes, we_root, we_hpo} = 4'hf;
        wa = hole_q;
        wk = rd_key_q;
        wb = rd_bytes_q;
        wr = rd_root_q;
        wh = rd_hpo_q;
      end
      WR_HOLE_CLR: begin
        we_hpo = 1'b1;
        wa     = hole_q;
        wh     = '0;
      end
      default: we_key = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_key)   mem_key[wa]   <= wk;
    if (we_bytes) mem_bytes[wa] <= wb;
    if (we_root)  mem_root[wa]  <= wr;
    if (we_hpo)   mem_hpo[wa]   <= wh;
    rd_key_q   <= mem_key[pos_q];
    rd_bytes_q <= mem_bytes[pos_q];
    rd_root_q  <= mem_root[pos_q];
    rd_hpo_q   <= mem_hpo[pos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_slots_q <= SLOTS_RESET;
      cfg_mode_q  <= MODE_RESET;
      pos_q       <= '0;
      total_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SLOTS: cfg_slots_q <= cfg_data_i;
          CFG_MODE:  cfg_mode_q  <= cfg_data_i[MODE_W-1:0];
          default:   cfg_mode_q  <= cfg_mode_q;
        endcase
      end
      pos_q <= pos_d;
      if (cmd_i.total_inc) begin
        total_q <= total_q + 1'b1;
      end else if (cmd_i.total_dec && total_q != '0) begin
        total_q <= total_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q   <= kind_e'(kind_i);
      key_q    <= key_i;
      bytes_q  <= byte_size_i;
      root_q   <= is_root_i;
      n_q      <= CNT_W'(n32);
      room_q   <= 1'b0;
      status_q <= ST_DONE;
      fsize_q  <= '0;
      froot_q  <= 1'b0;
    end
    if (cmd_i.home_load)  home_q <= rem_r[IDX_W-1:0];
    if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.dist_load)  dist_q <= dist_d;
    if (cmd_i.hole_load)  hole_q <= pos_q;
    if (cmd_i.room_set)   room_q <= 1'b1;
    if (cmd_i.carry_init) begin
      ck_q  <= key_q;
      cb_q  <= bytes_q;
      cr_q  <= root_q;
      cpo_q <= CNT_W'(home_q) + 1'b1;
      d_q   <= '0;
    end else begin
      if (cmd_i.carry_swap) begin
        ck_q  <= rd_key_q;
        cb_q  <= rd_bytes_q;
        cr_q  <= rd_root_q;
        cpo_q <= rd_hpo_q;
      end
      if (cmd_i.d_step) d_q <= d_nx;
    end
    if (cmd_i.res_found) begin
      fsize_q <= cmd_i.res_bytes_op ? bytes_q : rd_bytes_q;
      froot_q <= rd_root_q;
    end
    if (cmd_i.res_status_we) status_q <= cmd_i.res_status;
  end

  assign stat_o.mix_done    = mix_done;
  assign stat_o.rem_done    = rem_done;
  assign stat_o.empty       = (rd_hpo_q == '0);
  assign stat_o.key_eq      = (rd_key_q == key_q);
  assign stat_o.dist_lt_cnt = (W1'(dist_q) < W1'(cnt_q));
  assign stat_o.carry_ge    = (d_q >= dist_q);
  assign stat_o.dist_zero   = (dist_q == '0);
  assign stat_o.cnt_last    = ((W1'(cnt_q) + W1'(1)) == W1'(n_q));
  assign stat_o.nx_is_hole  = (pos_q == hole_q);
  assign stat_o.clr_last    = (pos_q == IDX_W'(SLOTS - 1));
  assign stat_o.room        = room_q;
  assign stat_o.kind        = kind_q;

  assign status_o         = status_q;
  assign found_size_o     = fsize_q;
  assign found_root_o     = froot_q;
  assign occupied_count_o = OCC_W'(total_q);

endmodule

/* rtl/core/rhpt_ctrl.sv */
// Operation sequencer: clearing pass, hashing, find, room scan, insert with
// displacement, backward-shift remove and size update. Drives rhpt_datapath. Uses rhpt_pkg.
`timescale 1ns / 1ps

module rhpt_ctrl import rhpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_MIX    = 5'd2;
  localparam logic [4:0] S_HREM   = 5'd3;
  localparam logic [4:0] S_F_INIT = 5'd4;
  localparam logic [4:0] S_F_RD   = 5'd5;
  localparam logic [4:0] S_F_EV   = 5'd6;
  localparam logic [4:0] S_F_DW   = 5'd7;
  localparam logic [4:0] S_F_CK   = 5'd8;
  localparam logic [4:0] S_FOUND  = 5'd9;
  localparam logic [4:0] S_NOTF   = 5'd10;
  localparam logic [4:0] S_S_INIT = 5'd11;
  localparam logic [4:0] S_S_RD   = 5'd12;
  localparam logic [4:0] S_S_EV   = 5'd13;
  localparam logic [4:0] S_I_INIT = 5'd14;
  localparam logic [4:0] S_I_RD   = 5'd15;
  localparam logic [4:0] S_I_EV   = 5'd16;
  localparam logic [4:0] S_I_DW   = 5'd17;
  localparam logic [4:0] S_I_CK   = 5'd18;
  localparam logic [4:0] S_R_NX   = 5'd19;
  localparam logic [4:0] S_R_RD   = 5'd20;
  localparam logic [4:0] S_R_EV   = 5'd21;
  localparam logic [4:0] S_R_DW   = 5'd22;
  localparam logic [4:0] S_R_CK   = 5'd23;
  localparam logic [4:0] S_R_END  = 5'd24;
  localparam logic [4:0] S_OUT    = 5'd25;

  logic [4:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_CLR: begin
        cmd_o.wr_sel  = WR_CLEAR;
        cmd_o.pos_sel = POS_INC;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch     = 1'b1;
          cmd_o.mix_start = 1'b1;
          state_d         = S_MIX;
        end
      end
      S_MIX: begin
        if (stat_i.mix_done) begin
          cmd_o.rem_start = 1'b1;
          cmd_o.rem_sel   = REM_HASH;
          state_d         = S_HREM;
        end
      end
      S_HREM: begin
        if (stat_i.rem_done) begin
          cmd_o.home_load = 1'b1;
          state_d         = S_F_INIT;
        end
      end
      S_F_INIT, S_S_INIT, S_I_INIT: begin
        cmd_o.pos_sel    = POS_HOME;
        cmd_o.cnt_clr    = 1'b1;
        cmd_o.carry_init = (state_q == S_I_INIT);
        state_d = (state_q == S_F_INIT) ? S_F_RD :
                  (state_q == S_S_INIT) ? S_S_RD : S_I_RD;
      end
      S_F_RD: state_d = S_F_EV;
      S_F_EV: begin
        if (stat_i.empty) begin
          cmd_o.room_set = 1'b1;
          state_d        = S_NOTF;
        end else begin
          cmd_o.rem_start = 1'b1;
          cmd_o.rem_sel   = REM_HOME;
          state_d         = S_F_DW;
        end
      end
      S_F_DW, S_I_DW, S_R_DW: begin
        cmd_o.rem_sel = REM_HOME;
        if (stat_i.rem_done) begin
          cmd_o.dist_load = 1'b1;
          state_d = (state_q == S_F_DW) ? S_F_CK :
                    (state_q == S_I_DW) ? S_I_CK : S_R_CK;
        end
      end
      S_F_CK: begin
        if (stat_i.dist_lt_cnt) begin
          state_d = S_NOTF;
        end else if (stat_i.key_eq) begin
          state_d = S_FOUND;
        end else if (stat_i.cnt_last) begin
          state_d = S_NOTF;
        end else begin
          cmd_o.pos_sel = POS_NEXT;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_F_RD;
        end
      end
      S_FOUND: begin
        cmd_o.res_found = 1'b1;
        cmd_o.cnt_clr   = 1'b1;
        state_d         = S_OUT;
        unique case (stat_i.kind)
          K_INSERT: begin
            cmd_o.res_status_we = 1'b1;
            cmd_o.res_status    = ST_PRESENT;
          end
          K_UPDATE: begin
            cmd_o.wr_sel       = WR_BYTES;
            cmd_o.res_bytes_op = 1'b1;
          end
          K_REMOVE: begin
            cmd_o.hole_load = 1'b1;
            state_d         = S_R_NX;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_NOTF: begin
        if (stat_i.kind != K_INSERT) begin
          cmd_o.res_status_we = 1'b1;
          cmd_o.res_status    = ST_NOTFOUND;
          state_d             = S_OUT;
        end else begin
          state_d = stat_i.room ? S_I_INIT : S_S_INIT;
        end
      end
      S_S_RD: state_d = S_S_EV;
      S_S_EV: begin
        if (stat_i.empty) begin
          state_d = S_I_INIT;
        end else if (stat_i.cnt_last) begin
          cmd_o.res_status_we = 1'b1;
          cmd_o.res_status    = ST_FULL;
          state_d             = S_OUT;
        end else begin
          cmd_o.pos_sel = POS_NEXT;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_S_RD;
        end
      end
      S_I_RD: state_d = S_I_EV;
      S_I_EV: begin
        if (stat_i.empty) begin
          cmd_o.wr_sel    = WR_CARRY;
          cmd_o.total_inc = 1'b1;
          state_d         = S_OUT;
        end else begin
          cmd_o.rem_start = 1'b1;
          cmd_o.rem_sel   = REM_HOME;
          state_d         = S_I_DW;
        end
      end
      S_I_CK: begin
        if (stat_i.carry_ge) begin
          cmd_o.wr_sel     = WR_CARRY;
          cmd_o.carry_swap = 1'b1;
        end
        cmd_o.d_step  = 1'b1;
        cmd_o.pos_sel = POS_NEXT;
        cmd_o.cnt_inc = 1'b1;
        state_d       = stat_i.cnt_last ? S_OUT : S_I_RD;
      end
      S_R_NX: begin
        cmd_o.pos_sel = POS_HOLE_NEXT;
        state_d       = S_R_RD;
      end
      S_R_RD: state_d = S_R_EV;
      S_R_EV: begin
        if (stat_i.nx_is_hole || stat_i.empty) begin
          state_d = S_R_END;
        end else begin
          cmd_o.rem_start = 1'b1;
          cmd_o.rem_sel   = REM_HOME;
          state_d         = S_R_DW;
        end
      end
      S_R_CK: begin
        if (stat_i.dist_zero) begin
          state_d = S_R_END;
        end else begin
          cmd_o.wr_sel    = WR_COPY;
          cmd_o.hole_load = 1'b1;
          cmd_o.cnt_inc   = 1'b1;
          state_d         = stat_i.cnt_last ? S_R_END : S_R_NX;
        end
      end
      S_R_END: begin
        cmd_o.wr_sel    = WR_HOLE_CLR;
        cmd_o.total_dec = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

endmodule

/* rtl/core/rhpt_checker.sv */
// Port-level checks of the pointer table core, bound to the top level.
// Depends on rhpt_pkg and robin_hood_pointer_table_core.
`timescale 1ns / 1ps

module rhpt_checker import rhpt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [1:0]        status_o,
  input logic [SIZE_W-1:0] found_size_o,
  input logic              found_root_o
);

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transfer left block idle");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result while idle");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_NOTFOUND || status_o == ST_FULL)) |->
    (found_size_o == '0 && !found_root_o)) else $error("miss reports entry");

endmodule

bind robin_hood_pointer_table_core rhpt_checker u_rhpt_checker (.*);

/* verif/robin_hood_pointer_table_core_tb.sv */
// Self-checking bench for the Robin Hood pointer table core: a directed table,
// then random phases under several slot counts and hash modes.
// Depends on rhpt_pkg and robin_hood_pointer_table_core.
`timescale 1ns / 1ps

module robin_hood_pointer_table_core_tb;
  import rhpt_pkg::*;

  typedef struct {
    logic [1:0]        status;
    logic [SIZE_W-1:0] size;
    logic              root;
    logic [OCC_W-1:0]  count;
  } table_res_t;

  typedef struct {
    logic              is_cfg;
    logic              cidx;
    logic [CFG_W-1:0]  cdata;
    kind_e             kind;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic              root;
    logic              typed;
    table_res_t        res;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        kind_i;
  logic [KEY_W-1:0]  key_i;
  logic [SIZE_W-1:0] byte_size_i;
  logic              is_root_i;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              done_o;
  logic [1:0]        status_o;
  logic [SIZE_W-1:0] found_size_o;
  logic              found_root_o;
  logic [OCC_W-1:0]  occupied_count_o;

  robin_hood_pointer_table_core i_dut (.*);

  // predictor state
  logic [KEY_W-1:0]  tbl_key  [SLOTS];
  logic [SIZE_W-1:0] tbl_size [SLOTS];
  logic              tbl_root [SLOTS];
  int unsigned       tbl_hp1  [SLOTS];
  int unsigned       tbl_total;
  logic [CFG_W-1:0]  slots_reg;
  logic [MODE_W-1:0] mode_reg;

  table_res_t        expected_q[$];
  stim_row_t         rows[$];
  logic [KEY_W-1:0]  key_pool[$];
  int                fails;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("FAIL robin_hood_pointer_table_core");
    $finish;
  end

  function automatic int unsigned active_n();
    if (slots_reg == 0) return 1;
    if (slots_reg > SLOTS) return SLOTS;
    return 32'(slots_reg);
  endfunction

  function automatic logic [63:0] home_hash(logic [63:0] k);
    if (mode_reg == 2'd1) begin
      k = (k + C_MIX1) + (k << 12);
      k = (k ^ C_MIX2) ^ (k >> 19);
      k = (k + C_MIX3) + (k << 5);
      k = (k + C_MIX4) ^ (k << 9);
      k = (k + C_MIX5) + (k << 3);
      k = (k ^ C_MIX6) ^ (k >> 16);
    end else if (mode_reg == 2'd2) begin
      k = (~k) + (k << 18);
      k = k ^ (k >> 31);
      k = k * 64'd21;
      k = k ^ (k >> 11);
      k = k + (k << 6);
      k = k ^ (k >> 22);
    end else begin
      k = ((k >> 16) ^ k) * {32'd0, C_SIMPLE};
      k = ((k >> 16) ^ k) * {32'd0, C_SIMPLE};
      k = (k >> 16) ^ k;
    end
    return (k >> 3) * {32'd0, C_GOLDEN};
  endfunction

  function automatic int unsigned dist_at(int unsigned pos, int unsigned n);
    int unsigned h;
    h = (tbl_hp1[pos] - 1) % n;
    return (pos + n - h) % n;
  endfunction

  function automatic int locate(logic [63:0] key, int unsigned n);
    int unsigned pos;
    pos = 32'(home_hash(key) % n);
    for (int unsigned i = 0; i < n; i++) begin
      if (tbl_hp1[pos] == 0) return -1;
      if (dist_at(pos, n) < i) return -1;
      if (tbl_key[pos] == key) return pos;
      pos = (pos + 1) % n;
    end
    return -1;
  endfunction

  function automatic table_res_t apply_op(kind_e kind, logic [63:0] key, logic [31:0] bytes,
                                          logic root);
    table_res_t r;
    int unsigned n, pos, d, rd, cpo, tp, hole, nx;
    int at;
    logic [63:0] ck, tk;
    logic [31:0] cb, tb;
    logic cr, tr, room;
    r = '{ST_DONE, '0, 1'b0, '0};
    n = active_n();
    at = locate(key, n);
    if (kind == K_INSERT) begin
      if (at >= 0) begin
        r.status = ST_PRESENT;
        r.size = tbl_size[at];
        r.root = tbl_root[at];
      end else begin
        room = 1'b0;
        for (int unsigned i = 0; i < n; i++) if (tbl_hp1[i] == 0) room = 1'b1;
        if (!room) begin
          r.status = ST_FULL;
        end else begin
          pos = 32'(home_hash(key) % n);
          d = 0;
          cpo = pos + 1;
          ck = key; cb = bytes; cr = root;
          for (int unsigned i = 0; i < n; i++) begin
            if (tbl_hp1[pos] == 0) begin
              tbl_key[pos] = ck; tbl_size[pos] = cb; tbl_root[pos] = cr;
              tbl_hp1[pos] = cpo;
              tbl_total++;
              break;
            end
            rd = dist_at(pos, n);
            if (d >= rd) begin
              tk = tbl_key[pos]; tb = tbl_size[pos]; tr = tbl_root[pos]; tp = tbl_hp1[pos];
              tbl_key[pos] = ck; tbl_size[pos] = cb; tbl_root[pos] = cr; tbl_hp1[pos] = cpo;
              ck = tk; cb = tb; cr = tr; cpo = tp;
              d = rd;
            end
            pos = (pos + 1) % n;
            d = (d + 1) % n;
          end
        end
      end
    end else if (at < 0) begin
      r.status = ST_NOTFOUND;
    end else if (kind == K_LOOKUP) begin
      r.size = tbl_size[at];
      r.root = tbl_root[at];
    end else if (kind == K_UPDATE) begin
      tbl_size[at] = bytes;
      r.size = bytes;
      r.root = tbl_root[at];
    end else begin
      hole = at;
      r.size = tbl_size[hole];
      r.root = tbl_root[hole];
      tbl_hp1[hole] = 0;
      for (int unsigned i = 0; i < n; i++) begin
        nx = (hole + 1) % n;
        if (tbl_hp1[nx] == 0 || dist_at(nx, n) == 0) break;
        tbl_key[hole] = tbl_key[nx]; tbl_size[hole] = tbl_size[nx];
        tbl_root[hole] = tbl_root[nx]; tbl_hp1[hole] = tbl_hp1[nx];
        tbl_hp1[nx] = 0;
        hole = nx;
      end
      if (tbl_total > 0) tbl_total--;
    end
    r.count = tbl_total[OCC_W-1:0];
    return r;
  endfunction

  // results
  always @(posedge clk_i) begin
    table_res_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing outstanding: status %0d", status_o);
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, status_o); fails++;
        end
        if (found_size_o !== e.size) begin
          $error("found_size: expected %h, actual %h", e.size, found_size_o); fails++;
        end
        if (found_root_o !== e.root) begin
          $error("found_root: expected %0d, actual %0d", e.root, found_root_o); fails++;
        end
        if (occupied_count_o !== e.count) begin
          $error("occupied_count: expected %0d, actual %0d", e.count, occupied_count_o);
          fails++;
        end
      end
    end
  end

  task automatic idle_gap();
    int r, g;
    r = $urandom_range(0, 99);
    g = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    repeat (g) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
    while (expected_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SLOTS) slots_reg = data;
    else mode_reg = data[MODE_W-1:0];
  endtask

  // hold start until the transfer, then predict
  task automatic send_op(kind_e kind, logic [63:0] key, logic [31:0] bytes, logic root,
                         logic typed, table_res_t tres);
    table_res_t p;
    start       <= 1'b1;
    kind_i      <= kind;
    key_i       <= key;
    byte_size_i <= bytes;
    is_root_i   <= root;
    do @(posedge clk_i); while (busy);
    p = apply_op(kind, key, bytes, root);
    expected_q.push_back(typed ? tres : p);
    if (kind == K_INSERT) key_pool.push_back(key);
    start <= 1'b0;
    @(posedge clk_i);
    idle_gap();
  endtask

  task automatic op_row(kind_e k, logic [63:0] key, logic [31:0] sz, logic rt,
                        logic typed = 1'b0, logic [1:0] st = 0, logic [31:0] fs = 0,
                        logic fr = 0, logic [10:0] cnt = 0);
    stim_row_t s;
    s = '{1'b0, 1'b0, '0, k, key, sz, rt, typed, '{st, fs, fr, cnt}};
    rows.push_back(s);
  endtask

  task automatic cfg_row(logic idx, logic [CFG_W-1:0] data);
    stim_row_t s;
    s = '{1'b1, idx, data, K_LOOKUP, '0, '0, 1'b0, 1'b0, '{0, 0, 0, 0}};
    rows.push_back(s);
  endtask

  initial begin
    logic [CFG_W-1:0] ph_slots [7];
    logic [MODE_W-1:0] ph_mode [7];
    logic [63:0] k;
    int r;
    kind_e kd;
    fails = 0;
    rst_ni = 1'b0; start = 1'b0; kind_i = '0; key_i = '0; byte_size_i = '0;
    is_root_i = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = 1'b0; cfg_data_i = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_key[i] = '0; tbl_size[i] = '0; tbl_root[i] = 1'b0; tbl_hp1[i] = 0;
    end
    tbl_total = 0;
    slots_reg = SLOTS_RESET;
    mode_reg  = MODE_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    op_row(K_LOOKUP, 64'd0, 32'd0, 1'b0, 1, ST_NOTFOUND, 0, 0, 0);
    op_row(K_INSERT, 64'd0, 32'd0, 1'b0, 1, ST_DONE, 0, 0, 1);
    op_row(K_INSERT, '1, '1, 1'b1, 1, ST_DONE, 0, 0, 2);
    op_row(K_INSERT, 64'd0, 32'd7, 1'b1, 1, ST_PRESENT, 0, 0, 2);
    op_row(K_LOOKUP, '1, 32'd0, 1'b0, 1, ST_DONE, '1, 1, 2);
    op_row(K_UPDATE, '1, 32'd5, 1'b0, 1, ST_DONE, 5, 1, 2);
    op_row(K_REMOVE, '1, 32'd0, 1'b0, 1, ST_DONE, 5, 1, 1);
    op_row(K_REMOVE, '1, 32'd0, 1'b0, 1, ST_NOTFOUND, 0, 0, 1);
    op_row(K_UPDATE, 64'h1234, 32'd9, 1'b1, 1, ST_NOTFOUND, 0, 0, 1);
    op_row(K_REMOVE, 64'd0, 32'd0, 1'b0, 1, ST_DONE, 0, 0, 0);
    cfg_row(CFG_SLOTS, 11'd1);
    op_row(K_INSERT, 64'ha5a5_a5a5_a5a5_a5a5, 32'd1, 1'b0, 1, ST_DONE, 0, 0, 1);
    op_row(K_INSERT, 64'h5a5a_5a5a_5a5a_5a5a, 32'd2, 1'b1, 1, ST_FULL, 0, 0, 1);
    op_row(K_LOOKUP, 64'ha5a5_a5a5_a5a5_a5a5, 32'd0, 1'b0);
    cfg_row(CFG_MODE, 11'd0);
    op_row(K_LOOKUP, 64'ha5a5_a5a5_a5a5_a5a5, 32'd0, 1'b0);
    cfg_row(CFG_MODE, 11'd2);
    op_row(K_INSERT, 64'h5a5a_5a5a_5a5a_5a5a, 32'd2, 1'b1, 1, ST_FULL, 0, 0, 1);
    cfg_row(CFG_MODE, 11'd3);
    op_row(K_REMOVE, 64'ha5a5_a5a5_a5a5_a5a5, 32'd0, 1'b0, 1, ST_DONE, 1, 0, 0);
    cfg_row(CFG_SLOTS, 11'd2047);
    op_row(K_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0001, 1'b1);
    op_row(K_INSERT, 64'h0123_4567_89ab_cdef, 32'h7fff_fffe, 1'b0);
    op_row(K_LOOKUP, 64'h8000_0000_0000_0001, 32'd0, 1'b0);
    op_row(K_REMOVE, 64'h0123_4567_89ab_cdef, 32'd0, 1'b0);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].cidx, rows[i].cdata);
      else send_op(rows[i].kind, rows[i].key, rows[i].size, rows[i].root,
                   rows[i].typed, rows[i].res);
    end

    ph_slots = '{11'd8, 11'd1024, 11'd3, 11'd0, 11'd2047, 11'd200, 11'd2};
    ph_mode  = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1};
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_SLOTS, ph_slots[ph]);
      write_reg(CFG_MODE, CFG_W'(ph_mode[ph]));
      for (int it = 0; it < 85; it++) begin
        r = $urandom_range(0, 99);
        kd = (r < 45) ? K_INSERT : (r < 65) ? K_LOOKUP : (r < 85) ? K_REMOVE : K_UPDATE;
        if (key_pool.size() != 0 && $urandom_range(0, 99) < 70)
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
          k = {$urandom, $urandom};
        send_op(kd, k, $urandom, 1'($urandom_range(0, 1)), 1'b0, '{0, 0, 0, 0});
      end
    end

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fails == 0) $display("PASS robin_hood_pointer_table_core");
    else $display("FAIL robin_hood_pointer_table_core");
    $finish;
  end

endmodule

/* files.f */
rtl/core/rhpt_pkg.sv
rtl/core/rhpt_mix.sv
rtl/core/rhpt_rem.sv
rtl/core/rhpt_datapath.sv
rtl/core/rhpt_ctrl.sv
rtl/core/robin_hood_pointer_table_core.sv
rtl/core/rhpt_checker.sv
verif/robin_hood_pointer_table_core_tb.sv
